>>> hw/rtl/iefc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iefc_pkg
// Shared types and codes for the input event frame coalescer.
// ----------------------------------------------------------------------------
package iefc_pkg;

    localparam int LIM_W   = 31;
    localparam int VAL_W   = 32;
    localparam int TYPE_W  = 16;
    localparam int CODE_W  = 16;
    localparam int CFG_IDX_W = 2;

    // result queue
    localparam int DEPTH   = 4;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int MAX_RES = 3;

    localparam logic [TYPE_W-1:0] EV_SYN = 16'd0;
    localparam logic [TYPE_W-1:0] EV_KEY = 16'd1;
    localparam logic [TYPE_W-1:0] EV_REL = 16'd2;
    localparam logic [TYPE_W-1:0] EV_ABS = 16'd3;

    localparam logic [CODE_W-1:0] CODE_X        = 16'h0000;
    localparam logic [CODE_W-1:0] CODE_Y        = 16'h0001;
    localparam logic [CODE_W-1:0] CODE_PRESSURE = 16'h0018;
    localparam logic [CODE_W-1:0] CODE_SYN_REPORT = 16'h0000;
    localparam logic [CODE_W-1:0] CODE_TOUCH    = 16'h014A;

    localparam logic [CFG_IDX_W-1:0] CFG_X_LIMIT        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_LIMIT        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_LIMIT = 2'd2;

    typedef enum logic [1:0] {
        KIND_REL = 2'd0,
        KIND_ABS = 2'd1,
        KIND_KEY = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind                    kind;
        logic signed [VAL_W-1:0]  rel_dx;
        logic signed [VAL_W-1:0]  rel_dy;
        logic [LIM_W-1:0]         pos_x;
        logic [LIM_W-1:0]         pos_y;
        logic signed [VAL_W-1:0]  pressure;
        logic [LIM_W-1:0]         x_scale;
        logic [LIM_W-1:0]         y_scale;
        logic [LIM_W-1:0]         pressure_scale;
        logic [CODE_W-1:0]        key_code;
        logic signed [VAL_W-1:0]  key_value;
        logic                     last;
    } t_result;

    // results of one event, already packed into slots from slot 0 upward
    typedef struct packed {
        logic [1:0]                count;
        t_result [MAX_RES-1:0]     res;
    } t_push;

endpackage

>>> hw/rtl/iefc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iefc_core
// Input register, axis latches and result generation for one event a cycle while the result queue has room.
// ----------------------------------------------------------------------------
module iefc_core
    import iefc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [TYPE_W-1:0]       i_ev_type,
    input  logic [CODE_W-1:0]       i_ev_code,
    input  logic signed [VAL_W-1:0] i_ev_value,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [LIM_W-1:0]        i_cfg_data,
    input  logic                    i_room,
    output t_push                   o_push
);

    logic                    r_in_valid;
    logic [TYPE_W-1:0]       r_ev_type;
    logic [CODE_W-1:0]       r_ev_code;
    logic signed [VAL_W-1:0] r_ev_value;

    logic [LIM_W-1:0] r_x_limit, r_y_limit, r_p_limit;

    logic signed [VAL_W-1:0] r_held_dx, n_held_dx;
    logic signed [VAL_W-1:0] r_held_dy, n_held_dy;
    logic signed [VAL_W-1:0] r_held_x, n_held_x;
    logic signed [VAL_W-1:0] r_held_y, n_held_y;
    logic signed [VAL_W-1:0] r_held_p, n_held_p;
    logic r_motion, n_motion;
    logic r_x_pend, n_x_pend;
    logic r_y_pend, n_y_pend;
    logic r_owed, n_owed;

    logic             fire;
    logic             is_sync;
    logic [LIM_W-1:0] clip_x, clip_y;
    t_result          rel_res, abs_res, td_res, key_res;
    t_push            push;

    function automatic logic [LIM_W-1:0] clip_axis(
        input logic signed [VAL_W-1:0] v,
        input logic [LIM_W-1:0]        lim
    );
        logic [LIM_W-1:0] c;
        if (v[VAL_W-1]) begin
            c = '0;
        end else if (v[LIM_W-1:0] > lim) begin
            c = lim;
        end else begin
            c = v[LIM_W-1:0];
        end
        return c;
    endfunction

    assign fire    = r_in_valid && i_room;
    assign o_stall = r_in_valid && !i_room;
    assign is_sync = (r_ev_type == EV_SYN) && (r_ev_code == CODE_SYN_REPORT);

    assign clip_x = clip_axis(r_held_x, r_x_limit);
    assign clip_y = clip_axis(r_held_y, r_y_limit);

    always_comb begin
        rel_res        = '0;
        rel_res.kind   = KIND_REL;
        rel_res.rel_dx = r_held_dx;
        rel_res.rel_dy = r_held_dy;

        abs_res                = '0;
        abs_res.kind           = KIND_ABS;
        abs_res.pos_x          = r_x_pend ? clip_x : '0;
        abs_res.x_scale        = r_x_pend ? r_x_limit : '0;
        abs_res.pos_y          = r_y_pend ? clip_y : '0;
        abs_res.y_scale        = r_y_pend ? r_y_limit : '0;
        abs_res.pressure       = r_held_p;
        abs_res.pressure_scale = r_p_limit;

        td_res           = '0;
        td_res.kind      = KIND_KEY;
        td_res.key_code  = CODE_TOUCH;
        td_res.key_value = 32'sd1;

        key_res           = '0;
        key_res.kind      = KIND_KEY;
        key_res.key_code  = r_ev_code;
        key_res.key_value = r_ev_value;
    end

    always_comb begin
        n_held_dx = r_held_dx;
        n_held_dy = r_held_dy;
        n_held_x  = r_held_x;
        n_held_y  = r_held_y;
        n_held_p  = r_held_p;
        n_motion  = r_motion;
        n_x_pend  = r_x_pend;
        n_y_pend  = r_y_pend;
        n_owed    = r_owed;
        push      = '0;

        if (fire) begin
            case (r_ev_type)
                EV_REL: begin
                    if (r_ev_code == CODE_X) begin
                        n_held_dx = r_ev_value;
                        n_motion  = 1'b1;
                    end else if (r_ev_code == CODE_Y) begin
                        n_held_dy = r_ev_value;
                        n_motion  = 1'b1;
                    end
                end
                EV_ABS: begin
                    if (r_ev_code == CODE_X) begin
                        n_held_x = r_ev_value;
                        n_x_pend = 1'b1;
                    end else if (r_ev_code == CODE_Y) begin
                        n_held_y = r_ev_value;
                        n_y_pend = 1'b1;
                    end else if (r_ev_code == CODE_PRESSURE) begin
                        n_held_p = r_ev_value;
                    end
                end
                EV_KEY: begin
                    // touch press is held back until the next position report
                    if (!(r_ev_code == CODE_TOUCH && r_ev_value != '0)) begin
                        if (r_ev_code == CODE_TOUCH) begin
                            n_owed = 1'b1;
                        end
                        push.res[0] = key_res;
                        push.count  = 2'd1;
                    end
                end
                EV_SYN: begin
                    if (is_sync) begin
                        if (r_motion) begin
                            n_motion    = 1'b0;
                            n_held_dx   = '0;
                            n_held_dy   = '0;
                            push.res[0] = rel_res;
                            push.count  = 2'd1;
                        end
                        if (r_x_pend || r_y_pend) begin
                            if (r_x_pend) begin
                                n_held_x = {1'b0, clip_x};
                                n_x_pend = 1'b0;
                            end
                            if (r_y_pend) begin
                                n_held_y = {1'b0, clip_y};
                                n_y_pend = 1'b0;
                            end
                            n_held_p = '0;
                            push.res[push.count] = abs_res;
                            push.count = push.count + 2'd1;
                            if (r_owed) begin
                                n_owed = 1'b0;
                                push.res[push.count] = td_res;
                                push.count = push.count + 2'd1;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end

        for (int k = 0; k < MAX_RES; k++) begin
            if (push.count != 2'd0 && (push.count - 2'd1) == 2'(k)) begin
                push.res[k].last = 1'b1;
            end
        end
    end

    assign o_push = push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!r_in_valid || fire) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((!r_in_valid || fire) && i_valid) begin
            r_ev_type  <= i_ev_type;
            r_ev_code  <= i_ev_code;
            r_ev_value <= i_ev_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_limit <= '0;
            r_y_limit <= '0;
            r_p_limit <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_X_LIMIT:        r_x_limit <= i_cfg_data;
                CFG_Y_LIMIT:        r_y_limit <= i_cfg_data;
                CFG_PRESSURE_LIMIT: r_p_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_dx <= '0;
            r_held_dy <= '0;
            r_held_x  <= '0;
            r_held_y  <= '0;
            r_held_p  <= '0;
            r_motion  <= 1'b0;
            r_x_pend  <= 1'b0;
            r_y_pend  <= 1'b0;
            r_owed    <= 1'b1;
        end else begin
            r_held_dx <= n_held_dx;
            r_held_dy <= n_held_dy;
            r_held_x  <= n_held_x;
            r_held_y  <= n_held_y;
            r_held_p  <= n_held_p;
            r_motion  <= n_motion;
            r_x_pend  <= n_x_pend;
            r_y_pend  <= n_y_pend;
            r_owed    <= n_owed;
        end
    end

    a_touch_down_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && is_sync && (r_x_pend || r_y_pend)) |=> (!r_owed && !r_x_pend && !r_y_pend))
        else $error("touch-down or axis flag not cleared after position report");

    a_motion_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && is_sync && r_motion) |=> (!r_motion && r_held_dx == '0 && r_held_dy == '0))
        else $error("relative deltas not cleared after motion report");

    a_held_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !fire) |=> (r_in_valid && $stable(r_ev_type) && $stable(r_ev_value)))
        else $error("waiting request lost or changed");

endmodule

>>> hw/rtl/iefc_result_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iefc_result_fifo
// Small result queue: takes up to three results a cycle, delivers one while the receiver does not stall.
// ----------------------------------------------------------------------------
module iefc_result_fifo
    import iefc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_room,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_head
);

    localparam logic [CNT_W-1:0] ROOM_LEVEL = CNT_W'(DEPTH - MAX_RES);

    t_result          r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             pop;

    assign o_valid = (r_count != '0);
    assign pop     = o_valid && !i_stall;
    assign o_room  = (r_count <= ROOM_LEVEL);
    assign o_head  = r_mem[r_rptr];
    assign n_count = r_count + CNT_W'(i_push.count) - CNT_W'(pop);

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RES; k++) begin
            if (2'(k) < i_push.count) begin
                r_mem[r_wptr + PTR_W'(k)] <= i_push.res[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + PTR_W'(i_push.count);
            r_rptr  <= r_rptr + PTR_W'(pop);
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != 2'd0) |-> ((r_count + CNT_W'(i_push.count)) <= CNT_W'(DEPTH)))
        else $error("result queue overflow");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("result count out of range");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wptr - r_rptr) == r_count[PTR_W-1:0])
        else $error("queue pointers disagree with count");

endmodule

>>> hw/rtl/input_event_frame_coalescer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// input_event_frame_coalescer_unit
// Coalesces key, relative and absolute input events into per-frame results.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries one event request: type, code
//   and signed value. Output channel (o_valid / i_stall) carries one result
//   request with its kind and fields; o_last marks the final result of an
//   event. Limits are written through i_cfg_we / i_cfg_addr / i_cfg_data
//   while the block is idle.
//   An event is registered on accept, evaluated from that register into the
//   result queue once the queue has room, and shown from the queue register.
//   Throughput: one event per cycle while each event makes at most one result
//   and the receiver does not stall. A sync report can make up to three
//   results, delivered one per cycle from the four-entry queue; input is
//   stalled while the queue holds more than one result, so the single output
//   port sets the rate there. Reset clears the queue, the latched axes and
//   the limits, and marks a touch-down as owed. A stalled receiver holds
//   the head result steady; o_stall holds an event while over one is queued.
// ----------------------------------------------------------------------------
module input_event_frame_coalescer_unit
    import iefc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [TYPE_W-1:0]       i_ev_type,
    input  logic [CODE_W-1:0]       i_ev_code,
    input  logic signed [VAL_W-1:0] i_ev_value,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [LIM_W-1:0]        i_cfg_data,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [1:0]              o_out_kind,
    output logic signed [VAL_W-1:0] o_rel_dx,
    output logic signed [VAL_W-1:0] o_rel_dy,
    output logic [LIM_W-1:0]        o_pos_x,
    output logic [LIM_W-1:0]        o_pos_y,
    output logic signed [VAL_W-1:0] o_pressure,
    output logic [LIM_W-1:0]        o_x_scale,
    output logic [LIM_W-1:0]        o_y_scale,
    output logic [LIM_W-1:0]        o_pressure_scale,
    output logic [CODE_W-1:0]       o_key_code,
    output logic signed [VAL_W-1:0] o_key_value,
    output logic                    o_last
);

    t_push   push;
    t_result head;
    logic    room;

    iefc_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_ev_type  (i_ev_type),
        .i_ev_code  (i_ev_code),
        .i_ev_value (i_ev_value),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_room     (room),
        .o_push     (push)
    );

    iefc_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_head  (head)
    );

    assign o_out_kind       = head.kind;
    assign o_rel_dx         = head.rel_dx;
    assign o_rel_dy         = head.rel_dy;
    assign o_pos_x          = head.pos_x;
    assign o_pos_y          = head.pos_y;
    assign o_pressure       = head.pressure;
    assign o_x_scale        = head.x_scale;
    assign o_y_scale        = head.y_scale;
    assign o_pressure_scale = head.pressure_scale;
    assign o_key_code       = head.key_code;
    assign o_key_value      = head.key_value;
    assign o_last           = head.last;

endmodule
